FILE: rtl/precedence_assoc_select_defines.svh
// Assertion macros shared by the precedence and associativity selector.
`ifndef PRECEDENCE_ASSOC_SELECT_DEFINES_SVH
`define PRECEDENCE_ASSOC_SELECT_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define PAS_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the cycle after.
`define PAS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/pas_pkg.sv
// Shared codes and constants for the precedence and associativity selector.
package pas_pkg;

    localparam int WINNER_BITS = 6;

    typedef enum logic [1:0] {
        ST_RESOLVED = 2'd0,
        ST_NO_MATCH = 2'd1,
        ST_ERROR    = 2'd2
    } t_status;

    localparam logic [1:0] ASSOC_NONE     = 2'd0;
    localparam logic [1:0] ASSOC_LEFT     = 2'd1;
    localparam logic [1:0] ASSOC_RIGHT    = 2'd2;
    localparam logic [1:0] ASSOC_NONASSOC = 2'd3;

endpackage

FILE: rtl/pas_stage.sv
// Input register that holds one candidate beat until the tracker takes it.
module pas_stage
    import pas_pkg::*;
#(
    parameter int PREC_BITS  = 16,
    parameter int SPLIT_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_active,
    input  logic signed [PREC_BITS-1:0]  i_precedence,
    input  logic [1:0]                   i_associativity,
    input  logic                         i_has_split,
    input  logic [SPLIT_BITS-1:0]        i_split_position,
    input  logic                         i_last_candidate,
    input  logic                         i_take,
    output logic                         o_valid,
    output logic                         o_active,
    output logic signed [PREC_BITS-1:0]  o_precedence,
    output logic [1:0]                   o_associativity,
    output logic                         o_has_split,
    output logic [SPLIT_BITS-1:0]        o_split_position,
    output logic                         o_last_candidate
);

    logic                        r_valid;
    logic                        r_active;
    logic signed [PREC_BITS-1:0] r_precedence;
    logic [1:0]                  r_associativity;
    logic                        r_has_split;
    logic [SPLIT_BITS-1:0]       r_split_position;
    logic                        r_last_candidate;
    logic                        w_load;

    // The register is free when empty or when its beat leaves this cycle.
    assign o_stall = r_valid && !i_take;
    assign w_load  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_active         <= i_active;
            r_precedence     <= i_precedence;
            r_associativity  <= i_associativity;
            r_has_split      <= i_has_split;
            r_split_position <= i_split_position;
            r_last_candidate <= i_last_candidate;
        end
    end

    assign o_valid          = r_valid;
    assign o_active         = r_active;
    assign o_precedence     = r_precedence;
    assign o_associativity  = r_associativity;
    assign o_has_split      = r_has_split;
    assign o_split_position = r_split_position;
    assign o_last_candidate = r_last_candidate;

endmodule

FILE: rtl/pas_track.sv
// Running group tracker and result register for one candidate set.
`include "precedence_assoc_select_defines.svh"

module pas_track
    import pas_pkg::*;
#(
    parameter int MAX_CANDIDATES = 64,
    parameter int PREC_BITS      = 16,
    parameter int SPLIT_BITS     = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_take,
    input  logic                         i_active,
    input  logic signed [PREC_BITS-1:0]  i_precedence,
    input  logic [1:0]                   i_associativity,
    input  logic                         i_has_split,
    input  logic [SPLIT_BITS-1:0]        i_split_position,
    input  logic                         i_last_candidate,
    output logic                         o_valid,
    input  logic                         i_stall,
    output t_status                      o_status,
    output logic [WINNER_BITS-1:0]       o_winner,
    output logic signed [PREC_BITS-1:0]  o_top_precedence
);

    localparam int CNT_BITS = $clog2(MAX_CANDIDATES + 2);
    localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_CANDIDATES);

    logic signed [PREC_BITS-1:0] r_best_prec, n_best_prec;
    logic                        r_prec_seen, n_prec_seen;
    logic                        r_error_seen, n_error_seen;
    logic                        r_winner_valid, n_winner_valid;
    logic [WINNER_BITS-1:0]      r_winner_pos, n_winner_pos;
    logic [SPLIT_BITS-1:0]       r_winner_split, n_winner_split;
    logic [CNT_BITS-1:0]         r_item_count, n_item_count;

    logic                        r_out_valid;
    t_status                     r_status, n_status;
    logic [WINNER_BITS-1:0]      r_winner, n_winner;
    logic signed [PREC_BITS-1:0] r_top, n_top;

    logic w_new_group;
    logic w_eligible;

    // A beat that closes a set needs the result register; others pass freely.
    assign o_take = i_valid && (!i_last_candidate || !r_out_valid || !i_stall);

    always_comb begin
        n_item_count   = (r_item_count <= CNT_MAX) ? r_item_count + 1'b1 : r_item_count;
        w_new_group    = i_active && (!r_prec_seen || (i_precedence > r_best_prec));
        n_best_prec    = w_new_group ? i_precedence : r_best_prec;
        n_prec_seen    = r_prec_seen || i_active;
        n_error_seen   = w_new_group ? 1'b0 : r_error_seen;
        n_winner_valid = w_new_group ? 1'b0 : r_winner_valid;
        n_winner_pos   = w_new_group ? '0 : r_winner_pos;
        n_winner_split = w_new_group ? '0 : r_winner_split;

        w_eligible = i_active && (i_precedence == n_best_prec) && i_has_split
                     && (i_associativity != ASSOC_NONE);
        if (w_eligible) begin
            if (i_associativity == ASSOC_NONASSOC) begin
                n_error_seen = 1'b1;
            end else if (!n_winner_valid) begin
                n_winner_valid = 1'b1;
                n_winner_pos   = WINNER_BITS'(r_item_count);
                n_winner_split = i_split_position;
            end else if (((i_associativity == ASSOC_LEFT) &&
                          (i_split_position > n_winner_split)) ||
                         ((i_associativity == ASSOC_RIGHT) &&
                          (i_split_position < n_winner_split))) begin
                n_winner_pos   = WINNER_BITS'(r_item_count);
                n_winner_split = i_split_position;
            end
        end

        n_status = ST_RESOLVED;
        n_winner = '0;
        n_top    = '0;
        if (n_item_count > CNT_MAX) begin
            n_status = ST_ERROR;
        end else if (!n_prec_seen) begin
            n_status = ST_NO_MATCH;
        end else begin
            n_top = n_best_prec;
            if (n_error_seen) begin
                n_status = ST_ERROR;
            end else if (!n_winner_valid) begin
                n_status = ST_NO_MATCH;
            end else begin
                n_winner = n_winner_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_prec    <= '0;
            r_prec_seen    <= 1'b0;
            r_error_seen   <= 1'b0;
            r_winner_valid <= 1'b0;
            r_winner_pos   <= '0;
            r_winner_split <= '0;
            r_item_count   <= '0;
        end else if (o_take) begin
            if (i_last_candidate) begin
                r_best_prec    <= '0;
                r_prec_seen    <= 1'b0;
                r_error_seen   <= 1'b0;
                r_winner_valid <= 1'b0;
                r_winner_pos   <= '0;
                r_winner_split <= '0;
                r_item_count   <= '0;
            end else begin
                r_best_prec    <= n_best_prec;
                r_prec_seen    <= n_prec_seen;
                r_error_seen   <= n_error_seen;
                r_winner_valid <= n_winner_valid;
                r_winner_pos   <= n_winner_pos;
                r_winner_split <= n_winner_split;
                r_item_count   <= n_item_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take && i_last_candidate) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_last_candidate) begin
            r_status <= n_status;
            r_winner <= n_winner;
            r_top    <= n_top;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_status;
    assign o_winner         = r_winner;
    assign o_top_precedence = r_top;

    `PAS_ASSERT_NEXT(a_set_close_clears, o_take && i_last_candidate, r_item_count == '0 && !r_prec_seen)
    `PAS_ASSERT_NEXT(a_close_gives_result, o_take && i_last_candidate, r_out_valid)
    `PAS_ASSERT_ALWAYS(a_count_saturates, r_item_count <= CNT_MAX + 1'b1)
    `PAS_ASSERT_ALWAYS(a_winner_needs_group, !r_winner_valid || r_prec_seen)

endmodule

FILE: rtl/precedence_assoc_select.sv
// Precedence and associativity selector: picks the winning parse candidate of a set.
//
// Candidates of one set stream in one beat per cycle, the last beat flagged by
// i_last_candidate; that beat produces one result beat with the status, the winner
// index and the top precedence. The block accepts a new candidate every cycle unless
// o_stall is high. The closing beat lands in the input register and then moves on
// to the result register, which offers the result once the tracker takes the beat.
// The running group registers (best precedence, error flag, winner and its split)
// are updated from each taken beat. A set longer than MAX_CANDIDATES reports an
// error. A stalled result holds back the next closing beat and the input behind it;
// candidates ahead of that beat keep flowing.
module precedence_assoc_select
    import pas_pkg::*;
#(
    parameter int MAX_CANDIDATES = 64,
    parameter int PREC_BITS      = 16,
    parameter int SPLIT_BITS     = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_active,
    input  logic signed [PREC_BITS-1:0]  i_precedence,
    input  logic [1:0]                   i_associativity,
    input  logic                         i_has_split,
    input  logic [SPLIT_BITS-1:0]        i_split_position,
    input  logic                         i_last_candidate,
    output logic                         o_valid,
    input  logic                         i_stall,
    output t_status                      o_status,
    output logic [WINNER_BITS-1:0]       o_winner,
    output logic signed [PREC_BITS-1:0]  o_top_precedence
);

    logic                        w_valid;
    logic                        w_take;
    logic                        w_active;
    logic signed [PREC_BITS-1:0] w_precedence;
    logic [1:0]                  w_associativity;
    logic                        w_has_split;
    logic [SPLIT_BITS-1:0]       w_split_position;
    logic                        w_last_candidate;

    pas_stage #(
        .PREC_BITS  (PREC_BITS),
        .SPLIT_BITS (SPLIT_BITS)
    ) u_stage (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_active         (i_active),
        .i_precedence     (i_precedence),
        .i_associativity  (i_associativity),
        .i_has_split      (i_has_split),
        .i_split_position (i_split_position),
        .i_last_candidate (i_last_candidate),
        .i_take           (w_take),
        .o_valid          (w_valid),
        .o_active         (w_active),
        .o_precedence     (w_precedence),
        .o_associativity  (w_associativity),
        .o_has_split      (w_has_split),
        .o_split_position (w_split_position),
        .o_last_candidate (w_last_candidate)
    );

    pas_track #(
        .MAX_CANDIDATES (MAX_CANDIDATES),
        .PREC_BITS      (PREC_BITS),
        .SPLIT_BITS     (SPLIT_BITS)
    ) u_track (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (w_valid),
        .o_take           (w_take),
        .i_active         (w_active),
        .i_precedence     (w_precedence),
        .i_associativity  (w_associativity),
        .i_has_split      (w_has_split),
        .i_split_position (w_split_position),
        .i_last_candidate (w_last_candidate),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_winner         (o_winner),
        .o_top_precedence (o_top_precedence)
    );

endmodule

FILE: tb/precedence_assoc_select_tb.sv
// Self-checking testbench for the precedence and associativity selector.
`timescale 1ns / 1ps

module precedence_assoc_select_tb;
    import pas_pkg::*;

    localparam int SET_LIMIT = 64;

    typedef struct {
        t_status                  status;
        logic [WINNER_BITS-1:0]   winner;
        logic signed [15:0]       top;
    } t_verdict;

    logic                       i_clk;
    logic                       i_rst_n          = 1'b0;
    logic                       i_valid          = 1'b0;
    logic                       o_stall;
    logic                       i_active         = 1'b0;
    logic signed [15:0]         i_precedence     = '0;
    logic [1:0]                 i_associativity  = ASSOC_NONE;
    logic                       i_has_split      = 1'b0;
    logic [15:0]                i_split_position = '0;
    logic                       i_last_candidate = 1'b0;
    logic                       o_valid;
    logic                       i_stall          = 1'b0;
    t_status                    o_status;
    logic [WINNER_BITS-1:0]     o_winner;
    logic signed [15:0]         o_top_precedence;

    // Expected verdicts, oldest first.
    t_verdict verdict_q[$];
    int       fail_count = 0;
    int       items_sent = 0;

    // Idling controls shared by the sender task and the receiver process.
    bit       sender_idle_en = 1'b0;
    bit       receiver_idle_en = 1'b0;
    int       receiver_hold_cycles = 0;

    // Running state of the selection, mirrored from accepted beats.
    logic signed [15:0] best_prec   = '0;
    bit                 prec_seen   = 1'b0;
    bit                 error_seen  = 1'b0;
    bit                 winner_ok   = 1'b0;
    int                 winner_idx  = 0;
    logic [15:0]        winner_split = '0;
    int                 cand_count  = 0;

    precedence_assoc_select dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_active         (i_active),
        .i_precedence     (i_precedence),
        .i_associativity  (i_associativity),
        .i_has_split      (i_has_split),
        .i_split_position (i_split_position),
        .i_last_candidate (i_last_candidate),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_winner         (o_winner),
        .o_top_precedence (o_top_precedence)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic report_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // Receiver: random stall bursts, or one long hold-off when a test asks for it.
    initial begin : receiver
        int burst;
        forever begin
            @(posedge i_clk);
            if (receiver_hold_cycles > 0) begin
                i_stall <= 1'b1;
                for (int c = 0; c < receiver_hold_cycles; c++) begin
                    @(posedge i_clk);
                end
                receiver_hold_cycles = 0;
                i_stall <= 1'b0;
            end else if (receiver_idle_en && $urandom_range(0, 9) == 0) begin
                burst = $urandom_range(1, 19);
                i_stall <= 1'b1;
                repeat (burst) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Checks each result beat and folds each accepted candidate into the prediction.
    always @(posedge i_clk) begin : scoreboard
        t_verdict due;
        int       idx;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (verdict_q.size() == 0) begin
                    report_failure($sformatf("result with none expected: status %0d winner %0d top %0d",
                                             o_status, o_winner, o_top_precedence));
                end else begin
                    due = verdict_q.pop_front();
                    if (o_status !== due.status || o_winner !== due.winner ||
                            o_top_precedence !== due.top) begin
                        report_failure($sformatf(
                            "expected status %0d winner %0d top %0d, got status %0d winner %0d top %0d",
                            due.status, due.winner, due.top,
                            o_status, o_winner, o_top_precedence));
                    end
                end
            end
            if (i_valid && !o_stall) begin
                idx = cand_count;
                if (cand_count <= SET_LIMIT) begin
                    cand_count++;
                end
                if (i_active) begin
                    // A strictly higher precedence starts a fresh group.
                    if (!prec_seen || i_precedence > best_prec) begin
                        best_prec    = i_precedence;
                        prec_seen    = 1'b1;
                        error_seen   = 1'b0;
                        winner_ok    = 1'b0;
                        winner_idx   = 0;
                        winner_split = '0;
                    end
                    if (i_precedence == best_prec && i_has_split &&
                            i_associativity != ASSOC_NONE) begin
                        if (i_associativity == ASSOC_NONASSOC) begin
                            error_seen = 1'b1;
                        end else if (!winner_ok) begin
                            winner_ok    = 1'b1;
                            winner_idx   = idx;
                            winner_split = i_split_position;
                        end else if ((i_associativity == ASSOC_LEFT &&
                                      i_split_position > winner_split) ||
                                     (i_associativity == ASSOC_RIGHT &&
                                      i_split_position < winner_split)) begin
                            winner_idx   = idx;
                            winner_split = i_split_position;
                        end
                    end
                end
                if (i_last_candidate) begin
                    due.winner = '0;
                    due.top    = '0;
                    if (cand_count > SET_LIMIT) begin
                        due.status = ST_ERROR;
                    end else if (!prec_seen) begin
                        due.status = ST_NO_MATCH;
                    end else begin
                        due.top = best_prec;
                        if (error_seen) begin
                            due.status = ST_ERROR;
                        end else if (!winner_ok) begin
                            due.status = ST_NO_MATCH;
                        end else begin
                            due.status = ST_RESOLVED;
                            due.winner = WINNER_BITS'(winner_idx);
                        end
                    end
                    verdict_q.push_back(due);
                    best_prec    = '0;
                    prec_seen    = 1'b0;
                    error_seen   = 1'b0;
                    winner_ok    = 1'b0;
                    winner_idx   = 0;
                    winner_split = '0;
                    cand_count   = 0;
                end
            end
        end
    end

    // Offers one candidate beat and returns at the edge that accepts it.
    task automatic send_candidate(input bit active, input logic signed [15:0] prec,
                                  input logic [1:0] assoc, input bit split_ok,
                                  input logic [15:0] split, input bit last);
        int gap;
        if (sender_idle_en && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 19);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_active         <= active;
        i_precedence     <= prec;
        i_associativity  <= assoc;
        i_has_split      <= split_ok;
        i_split_position <= split;
        i_last_candidate <= last;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    // Sender goes quiet until every expected verdict has come back.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        // Waiting for the edge lets the scoreboard record the beat accepted at this edge.
        @(posedge i_clk);
        wait (verdict_q.size() == 0);
        @(posedge i_clk);
    endtask

    task automatic send_random_set(input int count);
        logic signed [15:0] base;
        logic signed [15:0] prec;
        logic [1:0]         assoc;
        logic [15:0]        split;
        int                 pick;
        base = 16'($urandom);
        for (int k = 0; k < count; k++) begin
            // Precedences cluster near one value so that groups form and ties occur.
            if ($urandom_range(0, 5) == 0) begin
                prec = 16'($urandom);
            end else begin
                prec = base + 16'($urandom_range(0, 2));
            end
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                assoc = ASSOC_NONE;
            end else if (pick <= 4) begin
                assoc = ASSOC_LEFT;
            end else if (pick <= 8) begin
                assoc = ASSOC_RIGHT;
            end else begin
                assoc = ASSOC_NONASSOC;
            end
            if ($urandom_range(0, 1) == 0) begin
                split = 16'($urandom);
            end else begin
                split = 16'($urandom_range(0, 7));
            end
            send_candidate($urandom_range(0, 7) != 0, prec, assoc,
                           $urandom_range(0, 5) != 0, split, k == count - 1);
        end
    endtask

    task automatic test_directed();
        // Lone candidate at the top extremes.
        send_candidate(1, 16'sh7FFF, ASSOC_LEFT, 1, 16'hFFFF, 1);
        // Nothing active at all.
        send_candidate(0, 16'sh1234, ASSOC_LEFT, 1, 16'h0001, 1);
        // Lowest precedence; equal split does not replace; inactive beat is ignored.
        send_candidate(1, -16'sh8000, ASSOC_LEFT, 1, 16'h0000, 0);
        send_candidate(1, -16'sh8000, ASSOC_RIGHT, 1, 16'h0000, 0);
        send_candidate(1, -16'sh8000, ASSOC_NONE, 1, 16'h0005, 0);
        send_candidate(0, 16'sd100, ASSOC_LEFT, 1, 16'h0009, 1);
        // Left wants the larger split, right the smaller; splitless beats are skipped.
        send_candidate(1, 16'sd5, ASSOC_LEFT, 1, 16'd10, 0);
        send_candidate(1, 16'sd5, ASSOC_LEFT, 1, 16'd20, 0);
        send_candidate(1, 16'sd5, ASSOC_RIGHT, 1, 16'd3, 0);
        send_candidate(1, 16'sd5, ASSOC_NONASSOC, 0, 16'd1, 0);
        send_candidate(1, 16'sd5, ASSOC_LEFT, 1, 16'd15, 1);
        // Nonassociative in the top group fails the set wherever it sits.
        send_candidate(1, 16'sd7, ASSOC_NONASSOC, 1, 16'd4, 0);
        send_candidate(1, 16'sd7, ASSOC_LEFT, 1, 16'd8, 0);
        send_candidate(1, 16'sd7, ASSOC_RIGHT, 1, 16'd2, 1);
        // A higher precedence clears an earlier error; a lower nonassociative is moot.
        send_candidate(1, 16'sd3, ASSOC_NONASSOC, 1, 16'd4, 0);
        send_candidate(1, 16'sd9, ASSOC_LEFT, 1, 16'd1, 0);
        send_candidate(1, 16'sd2, ASSOC_NONASSOC, 1, 16'd6, 1);
        // Top group has no eligible candidate, yet the precedence is reported.
        send_candidate(1, 16'sd4, ASSOC_NONE, 1, 16'd3, 0);
        send_candidate(1, 16'sd4, ASSOC_LEFT, 0, 16'd3, 1);
        // Signed compare: a positive precedence beats a negative one.
        send_candidate(1, -16'sd5, ASSOC_LEFT, 1, 16'd1, 0);
        send_candidate(1, 16'sd3, ASSOC_RIGHT, 1, 16'd9, 1);
        wait_for_results();
    endtask

    task automatic test_set_length();
        int sizes[4] = '{SET_LIMIT, SET_LIMIT + 1, SET_LIMIT + 6, 1};
        foreach (sizes[s]) begin
            // Rising left splits make the final candidate the winner of each set within the limit.
            for (int k = 0; k < sizes[s]; k++) begin
                send_candidate(1, 16'sd12, ASSOC_LEFT, 1, 16'(k), k == sizes[s] - 1);
            end
        end
        wait_for_results();
    endtask

    task automatic test_random_sets();
        int stop_at;
        int size_pick;
        stop_at = items_sent + 1000;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                sender_idle_en   = $urandom_range(0, 1);
                receiver_idle_en = $urandom_range(0, 1);
            end
            size_pick = $urandom_range(0, 99);
            if (size_pick < 70) begin
                send_random_set($urandom_range(1, 6));
            end else if (size_pick < 97) begin
                send_random_set($urandom_range(7, 20));
            end else begin
                send_random_set($urandom_range(SET_LIMIT - 4, SET_LIMIT + 6));
            end
        end
        wait_for_results();
    endtask

    task automatic test_backpressure();
        sender_idle_en       = 1'b0;
        receiver_idle_en     = 1'b0;
        receiver_hold_cycles = 300;
        // Short sets close often, so results back up and the input stalls.
        for (int s = 0; s < 30; s++) begin
            send_random_set($urandom_range(1, 3));
        end
        wait_for_results();
    endtask

    task automatic test_steady_stream();
        int stop_at;
        sender_idle_en   = 1'b0;
        receiver_idle_en = 1'b0;
        stop_at = items_sent + 150;
        while (items_sent < stop_at) begin
            send_random_set($urandom_range(1, 8));
        end
        wait_for_results();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        sender_idle_en   = 1'b1;
        receiver_idle_en = 1'b1;
        test_set_length();
        test_random_sets();
        test_backpressure();
        test_steady_stream();
        repeat (10) @(posedge i_clk);
        fail_count += verdict_q.size();
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/pas_pkg.sv
rtl/pas_stage.sv
rtl/pas_track.sv
rtl/precedence_assoc_select.sv
tb/precedence_assoc_select_tb.sv
